### hdl/bftr_pkg.sv
// Shared types, constants and helpers for the bitmap font text rasterizer.
`timescale 1ns / 1ps

package bftr_pkg;

   localparam int STORE_BYTES = 16384;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   // Glyph layout address: (223 * 63 * 7) + row and byte offsets fits in 17 bits.
   localparam int LAYOUT_W    = 17;

   localparam logic [5:0] MAX_ROWS    = 6'd36;
   localparam logic [7:0] NEWLINE     = 8'd10;
   localparam logic [7:0] FIRST_GLYPH = 8'd32;

   localparam logic [5:0] HEIGHT_ONE_BYTE   = 6'd8;
   localparam logic [5:0] HEIGHT_TWO_BYTES  = 6'd16;
   localparam logic [5:0] HEIGHT_THREE_BYTES = 6'd24;
   localparam logic [5:0] HEIGHT_FOUR_BYTES = 6'd36;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_START = 2'd1,
      REQ_CHAR  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_FONT_WIDTH     = 3'd0,
      CSR_FONT_HEIGHT    = 3'd1,
      CSR_FONT_ROW_BYTES = 3'd2,
      CSR_SCREEN_WIDTH   = 3'd3,
      CSR_SCREEN_HEIGHT  = 3'd4
   } csr_index_type;

   // Row shaping controls handed from the sequencer to the mask aligner.
   typedef struct packed {
      logic       blank;
      logic [5:0] width;
      logic [1:0] nbytes_m1;
   } shape_type;

   // Saturating cursor step, clamps at 1023.
   function automatic logic [9:0] sat_add(input logic [9:0] a, input logic [5:0] b);
      logic [10:0] s;
      s = {1'b0, a} + {5'b0, b};
      return s[10] ? 10'h3FF : s[9:0];
   endfunction

endpackage

### hdl/bftr_glyph_ram.sv
// Glyph byte store: single port, registered read data.
`timescale 1ns / 1ps

module bftr_glyph_ram
   import bftr_pkg::*;
(
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wdata,
   output logic [7:0]        rdata
);

   logic [7:0] mem_ff [STORE_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/bftr_mask_align.sv
// Aligns the fetched row bytes to the font width and masks off unused columns.
`timescale 1ns / 1ps

module bftr_mask_align
   import bftr_pkg::*;
(
   input  logic [31:0] row_bits,
   input  shape_type   shape,
   output logic [31:0] row_mask
);

   logic [5:0]  width_eff;
   logic [5:0]  nbits;
   logic [2:0]  nbytes;
   logic [31:0] shifted;
   logic [32:0] keep;

   always_comb begin
      width_eff = (shape.width > 6'd32) ? 6'd32 : shape.width;
      nbytes    = {1'b0, shape.nbytes_m1} + 3'd1;
      nbits     = {nbytes, 3'b000};
      if (width_eff <= nbits) begin
         shifted = row_bits >> (nbits - width_eff);
      end else begin
         shifted = row_bits << (width_eff - nbits);
      end
      keep = (33'd1 << width_eff) - 33'd1;
      if (shape.blank || width_eff == 6'd0) begin
         row_mask = 32'h0;
      end else begin
         row_mask = shifted & keep[31:0];
      end
   end

endmodule

### hdl/bitmap_font_text_rasterizer.sv
// Text layout sequencer and top level of the bitmap font rasterizer.
`timescale 1ns / 1ps

// Load, start, newline, ignored and stopped requests are handled in S_IDLE alone. A
// character that runs past the bottom edge, or arrives while the font height is zero,
// passes S_WRAP and S_CHECK only. A drawn character runs the layout steps (accept,
// wrap test, bottom test with the glyph offset product, row base product), then for each
// emitted row S_FETCH once per row byte, S_LAST and S_EMIT, since the glyph store has
// one port and returns one byte a cycle; S_EMIT holds while rsp_tready is low and a
// row is pending. A finished row waits in the output register, so the next request is
// taken while the last row of a glyph is still pending.
module bitmap_font_text_rasterizer
   import bftr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // font_addr[13:0], font_byte[21:14], pos_x[30:22], pos_y[39:31],
   // text_color[55:40], char_code[63:56]
   input  logic [63:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // row_x[8:0], row_y[18:9], row_mask[50:19], pixel_color[66:51], zero[71:67]
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_WRAP, S_CHECK, S_BASE, S_FETCH, S_LAST, S_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [5:0]           fw_ff, fw_in, fh_ff, fh_in;
   logic [2:0]           frb_ff, frb_in;
   logic [8:0]           sw_ff, sw_in, sh_ff, sh_in;
   logic [9:0]           cursor_x_ff, cursor_x_in, cursor_y_ff, cursor_y_in;
   logic [8:0]           line_x_ff, line_x_in;
   logic [15:0]          color_ff, color_in;
   logic                 stopped_ff, stopped_in;
   logic [7:0]           code_ff, code_in;
   logic [13:0]          prod_ff, prod_in;
   logic [LAYOUT_W-1:0]  row_addr_ff, row_addr_in, addr_ff, addr_in;
   logic [1:0]           byte_ff, byte_in;
   logic [5:0]           row_ff, row_in, rows_ff, rows_in;
   logic                 pend_ff, pend_in, hit_ff, hit_in;
   logic [31:0]          acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [8:0]           rsp_x_ff, rsp_x_in;
   logic [9:0]           rsp_y_ff, rsp_y_in;
   logic [31:0]          rsp_mask_ff, rsp_mask_in;
   logic [15:0]          rsp_color_ff, rsp_color_in;

   logic [13:0]          font_addr;
   logic [7:0]           font_byte, char_code;
   logic [8:0]           pos_x, pos_y;
   logic [15:0]          text_color;
   req_kind_type         req_kind;
   logic                 req_fire;
   logic [LAYOUT_W-1:0]  load_addr;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_addr;
   logic [7:0]           ram_rdata;
   logic [1:0]           nbytes_m1;
   logic                 height_blank;
   logic [LAYOUT_W-1:0]  stride;
   logic [7:0]           glyph_idx;
   shape_type            shape;
   logic [31:0]          row_mask;
   logic                 out_free;
   logic                 last_of_glyph;

   assign font_addr  = req_tdata[13:0];
   assign font_byte  = req_tdata[21:14];
   assign pos_x      = req_tdata[30:22];
   assign pos_y      = req_tdata[39:31];
   assign text_color = req_tdata[55:40];
   assign char_code  = req_tdata[63:56];
   assign req_kind   = req_kind_type'(req_tuser);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_addr  = LAYOUT_W'(font_addr);

   assign ram_we   = req_fire && (req_kind == REQ_LOAD)
                     && (load_addr < LAYOUT_W'(STORE_BYTES));
   assign ram_addr = (state_ff == S_FETCH) ? addr_ff[ADDR_W-1:0] : load_addr[ADDR_W-1:0];

   bftr_glyph_ram u_glyph_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (font_byte),
      .rdata (ram_rdata)
   );

   // Row byte count follows the font height; other heights draw blank.
   always_comb begin
      height_blank = 1'b0;
      unique case (fh_ff)
         HEIGHT_ONE_BYTE:    nbytes_m1 = 2'd0;
         HEIGHT_TWO_BYTES:   nbytes_m1 = 2'd1;
         HEIGHT_THREE_BYTES: nbytes_m1 = 2'd2;
         HEIGHT_FOUR_BYTES:  nbytes_m1 = 2'd3;
         default: begin
            nbytes_m1    = 2'd0;
            height_blank = 1'b1;
         end
      endcase
   end

   assign stride    = (nbytes_m1 == 2'd0) ? LAYOUT_W'(1) : LAYOUT_W'(frb_ff);
   assign glyph_idx = code_ff - FIRST_GLYPH;

   assign shape.blank     = height_blank || (code_ff < FIRST_GLYPH);
   assign shape.width     = fw_ff;
   assign shape.nbytes_m1 = nbytes_m1;

   bftr_mask_align u_mask_align (
      .row_bits (acc_ff),
      .shape    (shape),
      .row_mask (row_mask)
   );

   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign last_of_glyph = (row_ff == rows_ff - 6'd1);

   always_comb begin
      state_in     = state_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      frb_in       = frb_ff;
      sw_in        = sw_ff;
      sh_in        = sh_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      line_x_in    = line_x_ff;
      color_in     = color_ff;
      stopped_in   = stopped_ff;
      code_in      = code_ff;
      prod_in      = prod_ff;
      row_addr_in  = row_addr_ff;
      addr_in      = addr_ff;
      byte_in      = byte_ff;
      row_in       = row_ff;
      rows_in      = rows_ff;
      pend_in      = 1'b0;
      hit_in       = hit_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_color_in = rsp_color_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_FONT_WIDTH:     fw_in  = csr_wdata[5:0];
            CSR_FONT_HEIGHT:    fh_in  = csr_wdata[5:0];
            CSR_FONT_ROW_BYTES: frb_in = csr_wdata[2:0];
            CSR_SCREEN_WIDTH:   sw_in  = csr_wdata;
            CSR_SCREEN_HEIGHT:  sh_in  = csr_wdata;
            default: ;
         endcase
      end

      // Shift in the byte requested last cycle, most significant first.
      if (pend_ff) begin
         acc_in = {acc_ff[23:0], hit_ff ? ram_rdata : 8'h00};
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_kind)
                  REQ_START: begin
                     cursor_x_in = {1'b0, pos_x};
                     line_x_in   = pos_x;
                     cursor_y_in = {1'b0, pos_y};
                     color_in    = text_color;
                     stopped_in  = 1'b0;
                  end
                  REQ_CHAR: begin
                     if (!stopped_ff) begin
                        code_in = char_code;
                        if (char_code == NEWLINE) begin
                           cursor_y_in = sat_add(cursor_y_ff, fh_ff);
                           cursor_x_in = {1'b0, line_x_ff};
                        end else begin
                           state_in = S_WRAP;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_WRAP: begin
            if ({1'b0, cursor_x_ff} + 11'(fw_ff) > 11'(sw_ff)) begin
               cursor_y_in = sat_add(cursor_y_ff, fh_ff);
               cursor_x_in = {1'b0, line_x_ff};
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            prod_in = {6'b0, glyph_idx} * {8'b0, fh_ff};
            rows_in = (fh_ff > MAX_ROWS) ? MAX_ROWS : fh_ff;
            row_in  = 6'd0;
            if ({1'b0, cursor_y_ff} + 11'(fh_ff) > 11'(sh_ff)) begin
               stopped_in = 1'b1;
               state_in   = S_IDLE;
            end else if (fh_ff == 6'd0) begin
               cursor_x_in = sat_add(cursor_x_ff, fw_ff);
               state_in    = S_IDLE;
            end else begin
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            row_addr_in = LAYOUT_W'(prod_ff) * LAYOUT_W'(frb_ff);
            addr_in     = LAYOUT_W'(prod_ff) * LAYOUT_W'(frb_ff);
            byte_in     = 2'd0;
            acc_in      = 32'h0;
            state_in    = S_FETCH;
         end
         S_FETCH: begin
            pend_in = 1'b1;
            hit_in  = addr_ff < LAYOUT_W'(STORE_BYTES);
            addr_in = addr_ff + LAYOUT_W'(1);
            byte_in = byte_ff + 2'd1;
            if (byte_ff == nbytes_m1) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = cursor_x_ff[8:0];
               rsp_y_in     = cursor_y_ff + 10'(row_ff);
               rsp_mask_in  = row_mask;
               rsp_color_in = color_ff;
               rsp_last_in  = last_of_glyph;
               row_in       = row_ff + 6'd1;
               row_addr_in  = row_addr_ff + stride;
               addr_in      = row_addr_ff + stride;
               byte_in      = 2'd0;
               acc_in       = 32'h0;
               if (last_of_glyph) begin
                  cursor_x_in = sat_add(cursor_x_ff, fw_ff);
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fw_ff        <= 6'd8;
         fh_ff        <= 6'd8;
         frb_ff       <= 3'd1;
         sw_ff        <= 9'd480;
         sh_ff        <= 9'd320;
         cursor_x_ff  <= 10'd0;
         cursor_y_ff  <= 10'd0;
         line_x_ff    <= 9'd0;
         color_ff     <= 16'h0;
         stopped_ff   <= 1'b1;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         frb_ff       <= frb_in;
         sw_ff        <= sw_in;
         sh_ff        <= sh_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         line_x_ff    <= line_x_in;
         color_ff     <= color_in;
         stopped_ff   <= stopped_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff      <= code_in;
      prod_ff      <= prod_in;
      row_addr_ff  <= row_addr_in;
      addr_ff      <= addr_in;
      byte_ff      <= byte_in;
      row_ff       <= row_in;
      rows_ff      <= rows_in;
      hit_ff       <= hit_in;
      acc_ff       <= acc_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_color_ff, rsp_mask_ff, rsp_y_ff, rsp_x_ff};

endmodule

### tb/sv/bitmap_font_text_rasterizer_tb.sv
// Self-checking testbench for the bitmap font text rasterizer: glyph loads, text layout, rows.
`timescale 1ns / 1ps

module bitmap_font_text_rasterizer_tb
   import bftr_pkg::*;
();

   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int unsigned CURSOR_LIMIT   = 1023;
   localparam int unsigned SETTLE_CYCLES  = 40;
   localparam int unsigned SQUEEZE_CYCLES = 600;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned MAX_REPORTS    = 10;

   typedef struct {
      logic [1:0]  kind;
      logic [13:0] font_addr;
      logic [7:0]  font_byte;
      logic [8:0]  pos_x;
      logic [8:0]  pos_y;
      logic [15:0] text_color;
      logic [7:0]  char_code;
   } text_req_type;

   typedef struct {
      logic [8:0]  x;
      logic [9:0]  y;
      logic [31:0] mask;
      logic [15:0] color;
      logic        last;
   } glyph_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // font_addr[13:0], font_byte[21:14], pos_x[30:22], pos_y[39:31],
   // text_color[55:40], char_code[63:56]
   logic [63:0] req_tdata = '0;
   // req_type[1:0]
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // row_x[8:0], row_y[18:9], row_mask[50:19], pixel_color[66:51], zero[71:67]
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_FONT_WIDTH;
   logic [8:0]  csr_wdata = '0;

   // register shadow, written only while the block is idle
   int unsigned cfg_width = 8;
   int unsigned cfg_height = 8;
   int unsigned cfg_row_bytes = 1;
   int unsigned cfg_screen_w = 480;
   int unsigned cfg_screen_h = 320;

   // layout state as the block should hold it
   logic [7:0]  font_copy [STORE_BYTES];
   int unsigned pen_x = 0;
   int unsigned pen_y = 0;
   int unsigned margin_x = 0;
   logic [15:0] ink = '0;
   bit          halted = 1'b1;

   bit            font_written [STORE_BYTES];
   logic [7:0]    loaded_codes [$];
   text_req_type  req_backlog [$];
   glyph_row_type rows_due [$];

   int unsigned issued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned rows_seen = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned stall_left = 0;
   int unsigned recv_calm = 0;
   int unsigned squeeze_left = 0;
   int unsigned squeezes_done = 0;

   bitmap_font_text_rasterizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic int unsigned cursor_step(input int unsigned a, input int unsigned b);
      return (a + b > CURSOR_LIMIT) ? CURSOR_LIMIT : a + b;
   endfunction

   function automatic int unsigned row_byte_count(input int unsigned h);
      case (h)
         HEIGHT_ONE_BYTE:    return 1;
         HEIGHT_TWO_BYTES:   return 2;
         HEIGHT_THREE_BYTES: return 3;
         HEIGHT_FOUR_BYTES:  return 4;
         default:            return 0;
      endcase
   endfunction

   // byte k of glyph row `row`; one-byte fonts pack rows tightly
   function automatic int unsigned glyph_addr(input logic [7:0] code, input int unsigned row,
                                              input int unsigned k);
      int unsigned stride;
      stride = (row_byte_count(cfg_height) == 1) ? 1 : cfg_row_bytes;
      return (code - FIRST_GLYPH) * cfg_height * cfg_row_bytes + row * stride + k;
   endfunction

   function automatic logic [31:0] glyph_row_bits(input logic [7:0] code, input int unsigned row);
      int unsigned nbytes, w, addr, k;
      logic [63:0] bits;
      logic [63:0] keep;
      if (code < FIRST_GLYPH) return '0;
      nbytes = row_byte_count(cfg_height);
      if (nbytes == 0) return '0;
      bits = '0;
      for (k = 0; k < nbytes; k++) begin
         addr = glyph_addr(code, row, k);
         bits = {bits[55:0], (addr < STORE_BYTES) ? font_copy[addr] : 8'h00};
      end
      w = (cfg_width > 32) ? 32 : cfg_width;
      if (w == 0) return '0;
      // align the stored bits to the glyph width, then clip to it
      if (w <= nbytes * 8) bits = bits >> (nbytes * 8 - w);
      else bits = bits << (w - nbytes * 8);
      keep = (64'd1 << w) - 64'd1;
      return 32'(bits & keep);
   endfunction

   task automatic predict_rows(input text_req_type rq);
      int unsigned rows, r;
      glyph_row_type gr;
      case (rq.kind)
         REQ_LOAD: font_copy[rq.font_addr] = rq.font_byte;
         REQ_START: begin
            pen_x = rq.pos_x;
            margin_x = rq.pos_x;
            pen_y = rq.pos_y;
            ink = rq.text_color;
            halted = 1'b0;
         end
         REQ_CHAR: begin
            if (!halted && rq.char_code == NEWLINE) begin
               pen_y = cursor_step(pen_y, cfg_height);
               pen_x = margin_x;
            end else if (!halted) begin
               if (pen_x + cfg_width > cfg_screen_w) begin
                  pen_y = cursor_step(pen_y, cfg_height);
                  pen_x = margin_x;
               end
               if (pen_y + cfg_height > cfg_screen_h) begin
                  halted = 1'b1;
               end else begin
                  rows = (cfg_height > MAX_ROWS) ? MAX_ROWS : cfg_height;
                  for (r = 0; r < rows; r++) begin
                     gr.x = 9'(pen_x);
                     gr.y = 10'(pen_y + r);
                     gr.mask = glyph_row_bits(rq.char_code, r);
                     gr.color = ink;
                     gr.last = (r + 1 == rows);
                     rows_due.push_back(gr);
                  end
                  pen_x = cursor_step(pen_x, cfg_width);
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic bit glyph_ready(input logic [7:0] code);
      int unsigned r, k, addr;
      if (code < FIRST_GLYPH) return 1'b1;
      for (r = 0; r < cfg_height; r++)
         for (k = 0; k < row_byte_count(cfg_height); k++) begin
            addr = glyph_addr(code, r, k);
            if (addr < STORE_BYTES && !font_written[addr]) return 1'b0;
         end
      return 1'b1;
   endfunction

   function automatic text_req_type noise_req(input logic [1:0] kind);
      text_req_type rq;
      rq.kind = kind;
      rq.font_addr = 14'($urandom);
      rq.font_byte = 8'($urandom);
      rq.pos_x = 9'($urandom);
      rq.pos_y = 9'($urandom);
      rq.text_color = 16'($urandom);
      rq.char_code = 8'($urandom);
      return rq;
   endfunction

   function automatic text_req_type start_req();
      text_req_type rq;
      rq = noise_req(REQ_START);
      // mostly land inside the screen so text gets drawn
      if ($urandom_range(0, 3) != 0) begin
         rq.pos_x = 9'($urandom_range(0, cfg_screen_w));
         rq.pos_y = 9'($urandom_range(0, cfg_screen_h));
      end
      return rq;
   endfunction

   task automatic queue_request(input text_req_type rq);
      if (rq.kind == REQ_LOAD) font_written[rq.font_addr] = 1'b1;
      req_backlog.push_back(rq);
      issued_count++;
   endtask

   task automatic send_char(input logic [7:0] code);
      text_req_type rq;
      rq = noise_req(REQ_CHAR);
      rq.char_code = code;
      queue_request(rq);
   endtask

   task automatic send_start(input logic [8:0] x, input logic [8:0] y, input logic [15:0] color);
      text_req_type rq;
      rq = noise_req(REQ_START);
      rq.pos_x = x;
      rq.pos_y = y;
      rq.text_color = color;
      queue_request(rq);
   endtask

   task automatic send_load(input logic [13:0] addr, input logic [7:0] value);
      text_req_type rq;
      rq = noise_req(REQ_LOAD);
      rq.font_addr = addr;
      rq.font_byte = value;
      queue_request(rq);
   endtask

   // fill only the glyph bytes that hold nothing yet; overlapping rows share bytes
   task automatic load_glyph(input logic [7:0] code);
      int unsigned r, k, addr;
      loaded_codes.push_back(code);
      for (r = 0; r < cfg_height; r++)
         for (k = 0; k < row_byte_count(cfg_height); k++) begin
            addr = glyph_addr(code, r, k);
            if (addr < STORE_BYTES && !font_written[addr]) send_load(14'(addr), 8'($urandom));
         end
   endtask

   task automatic prepare_font();
      loaded_codes.delete();
      load_glyph(FIRST_GLYPH);
      load_glyph(8'($urandom_range(33, 255)));
   endtask

   task automatic random_text(input int unsigned count);
      text_req_type rq;
      int unsigned made, roll, run;
      made = 0;
      queue_request(start_req());
      while (made < count) begin
         rq = noise_req(REQ_CHAR);
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            rq.kind = REQ_LOAD;
            made++;
         end else if (roll < 13) begin
            rq = start_req();
            made++;
         end else if (roll < 16) begin
            rq.kind = REQ_UNUSED;
         end else if (roll < 18) begin
            // long newline run pushes the cursor toward saturation
            rq.char_code = NEWLINE;
            run = $urandom_range(20, 40);
            repeat (run - 1) queue_request(rq);
            made += run;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               rq.char_code = NEWLINE;
            end else if (roll < 22) begin
               rq.char_code = 8'($urandom_range(0, 31));
            end else begin
               rq.char_code = 8'($urandom_range(32, 255));
               if (!glyph_ready(rq.char_code))
                  rq.char_code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
            end
            made++;
         end
         queue_request(rq);
      end
   endtask

   task automatic drain_and_settle();
      while (accepted_count != issued_count || rows_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(input int unsigned w, input int unsigned h,
                                 input int unsigned rb, input int unsigned sw,
                                 input int unsigned sh);
      cfg_width = w;
      cfg_height = h;
      cfg_row_bytes = rb;
      cfg_screen_w = sw;
      cfg_screen_h = sh;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_FONT_WIDTH;
      csr_wdata <= 9'(w);
      @(posedge clock);
      csr_index <= CSR_FONT_HEIGHT;
      csr_wdata <= 9'(h);
      @(posedge clock);
      csr_index <= CSR_FONT_ROW_BYTES;
      csr_wdata <= 9'(rb);
      @(posedge clock);
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= 9'(sw);
      @(posedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= 9'(sh);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin : driver
      text_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_calm > 0) send_calm--;
         else if ($urandom_range(0, 199) == 0) send_calm = $urandom_range(100, 400);
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            nxt = req_backlog.pop_front();
            req_tdata <= {nxt.char_code, nxt.text_color, nxt.pos_y, nxt.pos_x,
                          nxt.font_byte, nxt.font_addr};
            req_tuser <= nxt.kind;
            req_tvalid <= 1'b1;
            send_gap = (send_calm > 0) ? 0 : idle_len();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // row receiver, with long hold-offs so the block backs up into its input
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (recv_calm > 0) recv_calm--;
         else if ($urandom_range(0, 199) == 0) recv_calm = $urandom_range(100, 400);
         if (squeeze_left > 0) begin
            squeeze_left--;
            rsp_tready <= 1'b0;
         end else if ((squeezes_done == 0 && rows_seen >= 40) ||
                      (squeezes_done == 1 && rows_seen >= 700)) begin
            squeezes_done++;
            squeeze_left = SQUEEZE_CYCLES;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (recv_calm == 0 && $urandom_range(0, 4) == 0) stall_left = idle_len();
         end
      end
   end

   // check rows before predicting, so a row never meets a request taken at the same edge
   always @(posedge clock) begin : monitor
      glyph_row_type want;
      glyph_row_type got;
      text_req_type seen;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rows_seen <= rows_seen + 1;
            got.x = rsp_tdata[8:0];
            got.y = rsp_tdata[18:9];
            got.mask = rsp_tdata[50:19];
            got.color = rsp_tdata[66:51];
            got.last = rsp_tlast;
            if (rows_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected row: x=%0d y=%0d mask=%h color=%h last=%0b",
                           got.x, got.y, got.mask, got.color, got.last);
            end else begin
               want = rows_due.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.mask !== want.mask ||
                   got.color !== want.color || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"row mismatch: expected x=%0d y=%0d mask=%h color=%h last=%0b,",
                               " got x=%0d y=%0d mask=%h color=%h last=%0b"},
                              want.x, want.y, want.mask, want.color, want.last,
                              got.x, got.y, got.mask, got.color, got.last);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            accepted_count <= accepted_count + 1;
            seen.font_addr = req_tdata[13:0];
            seen.font_byte = req_tdata[21:14];
            seen.pos_x = req_tdata[30:22];
            seen.pos_y = req_tdata[39:31];
            seen.text_color = req_tdata[55:40];
            seen.char_code = req_tdata[63:56];
            seen.kind = req_tuser;
            predict_rows(seen);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bitmap_font_text_rasterizer_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 8x8 font, 480x320 screen
      prepare_font();
      load_glyph(8'd65);
      load_glyph(8'd255);
      send_load(14'h3FFF, 8'hFF);
      send_char(8'd65);                   // still stopped out of reset
      send_start(9'd0, 9'd0, 16'hFFFF);
      send_char(8'd65);
      send_char(8'd255);
      send_char(FIRST_GLYPH);
      send_char(8'd0);                    // control codes draw blank but advance
      send_char(8'd31);
      send_char(NEWLINE);
      send_char(8'd65);
      queue_request(noise_req(REQ_UNUSED));
      send_start(9'd472, 9'd0, 16'h0000);
      send_char(8'd65);                   // ends exactly on the right edge
      send_char(8'd65);                   // wraps
      send_start(9'd511, 9'd511, 16'hA5A5);
      send_char(8'd65);                   // wraps past the bottom and stops
      send_char(8'd65);
      send_char(NEWLINE);
      send_start(9'd0, 9'd312, 16'h5A5A);
      send_char(8'd65);                   // last line that fits
      send_char(NEWLINE);
      send_char(8'd65);
      random_text(25);
      drain_and_settle();

      // full 32-bit rows, glyph rows overlapping in the store
      apply_settings(32, 36, 1, 511, 511);
      prepare_font();
      random_text(15);
      drain_and_settle();

      // width above 32 clips to 32 columns
      apply_settings(40, 16, 2, 100, 60);
      prepare_font();
      random_text(15);
      drain_and_settle();

      apply_settings(1, 24, 1, 64, 200);
      prepare_font();
      random_text(10);
      drain_and_settle();

      apply_settings(0, 8, 0, 480, 320);
      prepare_font();
      random_text(10);
      drain_and_settle();

      apply_settings(1, 0, 5, 1, 1);
      prepare_font();
      random_text(10);
      drain_and_settle();

      apply_settings(13, 63, 6, 200, 511);
      prepare_font();
      random_text(10);
      drain_and_settle();

      if (mismatches == 0 && rows_due.size() == 0) begin
         $display("bitmap_font_text_rasterizer_tb passed");
      end else begin
         $display("bitmap_font_text_rasterizer_tb failed");
      end
      $finish;
   end

endmodule
